// File: src/pse_pkg.sv
// Shared types and constants of the postfix stack evaluator.
package pse_pkg;

  localparam int unsigned ValW  = 64;
  localparam int unsigned IterW = $clog2(ValW);

  typedef enum logic [2:0] {
    KIND_PUSH = 3'd0,
    KIND_ADD  = 3'd1,
    KIND_SUB  = 3'd2,
    KIND_MUL  = 3'd3,
    KIND_DIV  = 3'd4,
    KIND_SKIP = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_LEFTOVER  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_DIVZERO   = 3'd4,
    ST_EMPTY     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_ITER,
    S_FIN
  } state_e;

endpackage

// File: src/pse_if.sv
// Token and result channel interfaces of the postfix stack evaluator.
interface pse_tok_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [63:0] operand_value;
  logic        last_token;

  modport source (output valid, kind, operand_value, last_token, input ready);
  modport sink   (input valid, kind, operand_value, last_token, output ready);
endinterface

interface pse_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] top_value;
  logic [2:0]  status;

  modport source (output valid, top_value, status, input ready);
  modport sink   (input valid, top_value, status, output ready);
endinterface

// File: src/postfix_stack_evaluator.sv
// Postfix evaluator top level: value stack memory, sequencer and bit-serial mul/div.
// Push, ignored and error tokens are handled in S_IDLE; a result word is shown the cycle after they are taken.
// Add and subtract go through stack memory read (registered), execute and write back.
// Multiply and divide run a shift-add / restoring loop in S_ITER over every operand bit (one bit a cycle).
// Reset is asynchronous: clears count, error and control; the stack memory is not cleared.
module postfix_stack_evaluator
  import pse_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  pse_tok_if.sink   tok_i,
  pse_res_if.source res_o
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(STACK_DEPTH);
  localparam logic [IterW-1:0] IterLast = '1;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  status_e           err_q, err_d;
  kind_e             kind_q, kind_d;
  logic              last_q, last_d;
  logic [ValW-1:0]   top_q, top_d;
  logic [ValW-1:0]   acc_q, acc_d;
  logic [ValW-1:0]   opa_q, opa_d;
  logic [ValW-1:0]   opb_q, opb_d;
  logic [IterW-1:0]  iter_q, iter_d;
  logic              out_valid_q, out_valid_d;
  logic [ValW-1:0]   out_top_q, out_top_d;
  status_e           out_status_q, out_status_d;

  logic [ValW-1:0]   stack_mem_q [STACK_DEPTH];
  logic [ValW-1:0]   rd_data_q;
  logic              wr_en, rd_en;
  logic [IdxW-1:0]   wr_addr, rd_addr;
  logic [CntW-1:0]   cnt_m1, cnt_m2;

  logic              tok_ready;
  logic              finish, fin_last;
  logic [ValW:0]     rem_sh, rem_diff;

  assign cnt_m1  = count_q - CntW'(1);
  assign cnt_m2  = count_q - CntW'(2);
  assign wr_addr = cnt_m1[IdxW-1:0];
  assign rd_addr = cnt_m2[IdxW-1:0];
  assign rem_sh   = {acc_q, opb_q[ValW-1]};
  assign rem_diff = rem_sh - {1'b0, opa_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem_q[wr_addr] <= top_q;
    end
    if (rd_en) begin
      rd_data_q <= stack_mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    last_q       <= last_d;
    top_q        <= top_d;
    acc_q        <= acc_d;
    opa_q        <= opa_d;
    opb_q        <= opb_d;
    iter_q       <= iter_d;
    out_top_q    <= out_top_d;
    out_status_q <= out_status_d;
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    err_d        = err_q;
    kind_d       = kind_q;
    last_d       = last_q;
    top_d        = top_q;
    acc_d        = acc_q;
    opa_d        = opa_q;
    opb_d        = opb_q;
    iter_d       = iter_q;
    out_valid_d  = out_valid_q;
    out_top_d    = out_top_q;
    out_status_d = out_status_q;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    tok_ready    = 1'b0;
    finish       = 1'b0;
    fin_last     = 1'b0;

    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        tok_ready = !out_valid_q || res_o.ready;
        fin_last  = tok_i.last_token;
        if (tok_ready && tok_i.valid) begin
          kind_d = kind_e'(tok_i.kind);
          last_d = tok_i.last_token;
          if (err_q != ST_OK) begin
            finish = 1'b1;
          end else begin
            case (kind_e'(tok_i.kind))
              KIND_PUSH: begin
                finish = 1'b1;
                if (count_q == CntW'(STACK_DEPTH)) begin
                  err_d = ST_OVERFLOW;
                end else begin
                  wr_en   = (count_q != '0);
                  top_d   = tok_i.operand_value;
                  count_d = count_q + CntW'(1);
                end
              end
              KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
                if (count_q < CntW'(2)) begin
                  err_d  = ST_UNDERFLOW;
                  finish = 1'b1;
                end else if (kind_e'(tok_i.kind) == KIND_DIV && top_q == '0) begin
                  err_d  = ST_DIVZERO;
                  finish = 1'b1;
                end else begin
                  rd_en   = 1'b1;
                  state_d = S_EXEC;
                end
              end
              default: begin
                finish = 1'b1;
              end
            endcase
          end
        end
      end
      S_EXEC: begin
        iter_d = '0;
        case (kind_q)
          KIND_ADD: begin
            acc_d   = rd_data_q + top_q;
            state_d = S_FIN;
          end
          KIND_SUB: begin
            acc_d   = rd_data_q - top_q;
            state_d = S_FIN;
          end
          KIND_MUL: begin
            acc_d   = '0;
            opa_d   = rd_data_q;
            opb_d   = top_q;
            state_d = S_ITER;
          end
          KIND_DIV: begin
            acc_d   = '0;
            opa_d   = top_q;
            opb_d   = rd_data_q;
            state_d = S_ITER;
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end
      S_ITER: begin
        iter_d = iter_q + IterW'(1);
        if (kind_q == KIND_MUL) begin
          if (opb_q[0]) begin
            acc_d = acc_q + opa_q;
          end
          opa_d = {opa_q[ValW-2:0], 1'b0};
          opb_d = {1'b0, opb_q[ValW-1:1]};
        end else begin
          if (!rem_diff[ValW]) begin
            acc_d = rem_diff[ValW-1:0];
            opb_d = {opb_q[ValW-2:0], 1'b1};
          end else begin
            acc_d = rem_sh[ValW-1:0];
            opb_d = {opb_q[ValW-2:0], 1'b0};
          end
        end
        if (iter_q == IterLast) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        fin_last = last_q;
        if (!(last_q && out_valid_q && !res_o.ready)) begin
          top_d   = (kind_q == KIND_DIV) ? opb_q : acc_q;
          count_d = cnt_m1;
          finish  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (finish && fin_last) begin
      out_valid_d = 1'b1;
      out_top_d   = (count_d != '0) ? top_d : '0;
      if (err_d != ST_OK) begin
        out_status_d = err_d;
      end else if (count_d == '0) begin
        out_status_d = ST_EMPTY;
      end else if (count_d > CntW'(1)) begin
        out_status_d = ST_LEFTOVER;
      end else begin
        out_status_d = ST_OK;
      end
      count_d = '0;
      err_d   = ST_OK;
    end
  end

  assign tok_i.ready     = tok_ready;
  assign res_o.valid     = out_valid_q;
  assign res_o.top_value = out_top_q;
  assign res_o.status    = out_status_q;

endmodule

// File: src/pse_checker.sv
// Port-level assertions of the postfix stack evaluator and their binding.
module pse_checker
  import pse_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        tok_valid_i,
  input logic        tok_ready_i,
  input logic [2:0]  tok_kind_i,
  input logic        tok_last_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [63:0] res_top_i,
  input logic [2:0]  res_status_i
);

  logic tok_acc;
  logic tok_not_op;

  assign tok_acc    = tok_valid_i && tok_ready_i;
  assign tok_not_op = !(tok_kind_i == KIND_ADD || tok_kind_i == KIND_SUB ||
                        tok_kind_i == KIND_MUL || tok_kind_i == KIND_DIV);

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_status_i == ST_EMPTY |-> res_top_i == '0)
    else $error("empty result carries a non-zero top value");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_top_i) &&
                                    $stable(res_status_i))
    else $error("stalled result word changed");

  a_fast_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_acc && tok_last_i && tok_not_op |=> res_valid_i)
    else $error("last non-operator token gave no result next cycle");

  a_no_take_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |-> !tok_ready_i)
    else $error("token taken while the result word is stalled");

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .tok_valid_i  (tok_i.valid),
  .tok_ready_i  (tok_i.ready),
  .tok_kind_i   (tok_i.kind),
  .tok_last_i   (tok_i.last_token),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_top_i    (res_o.top_value),
  .res_status_i (res_o.status)
);

// File: verif/tb_postfix_stack_evaluator.sv
// Testbench for the postfix stack evaluator: directed table, random expressions, scoreboard.
module tb_postfix_stack_evaluator
  import pse_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth       = 16;
  localparam int unsigned TokenTarget = 1450;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned ReportLimit = 10;

  localparam logic [63:0] AllOnes     = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [2:0]  KIND_SPARE6 = 3'd6;
  localparam logic [2:0]  KIND_SPARE7 = 3'd7;

  typedef struct {
    logic [63:0] top;
    status_e     status;
  } result_t;

  typedef struct {
    logic [2:0]  kind;
    logic [63:0] val;
    logic        last;
    bit          typed;
    logic [63:0] top;
    status_e     status;
  } token_row_t;

  logic clk_i;
  logic rst_ni;

  pse_tok_if tok ();
  pse_res_if res ();

  postfix_stack_evaluator #(
    .STACK_DEPTH(Depth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tok_i (tok),
    .res_o (res)
  );

  logic [63:0] eval_stack [Depth];
  int          eval_depth = 0;
  status_e     eval_fault = ST_OK;

  result_t     pending_results [$];
  int          mismatches    = 0;
  int unsigned worked_tokens = 0;
  int unsigned cycles        = 0;
  bit          calm          = 1'b0;

  token_row_t dir_rows [24] = '{
    '{KIND_SKIP,   64'd0,   1'b1, 1'b1, 64'd0,   ST_EMPTY},
    '{KIND_PUSH,   AllOnes, 1'b0, 1'b0, 64'd0,   ST_OK},
    '{KIND_PUSH,   64'd1,   1'b0, 1'b0, 64'd0,   ST_OK},
    '{KIND_ADD,    64'd0,   1'b1, 1'b1, 64'd0,   ST_OK},
    '{KIND_PUSH,   64'd0,   1'b0, 1'b0, 64'd0,   ST_OK},
    '{KIND_PUSH,   64'd1,   1'b0, 1'b0, 64'd0,   ST_OK},
    '{KIND_SUB,    64'd0,   1'b1, 1'b1, AllOnes, ST_OK},
    '{KIND_PUSH,   AllOnes, 1'b0, 1'b0, 64'd0,   ST_OK},
    '{KIND_PUSH,   AllOnes, 1'b0, 1'b0, 64'd0,   ST_OK},
    '{KIND_MUL,    AllOnes, 1'b1, 1'b1, 64'd1,   ST_OK},
    '{KIND_PUSH,   64'd7,   1'b0, 1'b0, 64'd0,   ST_OK},
    '{KIND_PUSH,   64'd0,   1'b0, 1'b0, 64'd0,   ST_OK},
    '{KIND_DIV,    64'd0,   1'b0, 1'b0, 64'd0,   ST_OK},
    '{KIND_PUSH,   64'd9,   1'b1, 1'b1, 64'd0,   ST_DIVZERO},
    '{KIND_ADD,    64'd0,   1'b1, 1'b1, 64'd0,   ST_UNDERFLOW},
    '{KIND_PUSH,   64'd4,   1'b0, 1'b0, 64'd0,   ST_OK},
    '{KIND_SUB,    64'd0,   1'b1, 1'b1, 64'd4,   ST_UNDERFLOW},
    '{KIND_PUSH,   64'd5,   1'b0, 1'b0, 64'd0,   ST_OK},
    '{KIND_SPARE6, AllOnes, 1'b0, 1'b0, 64'd0,   ST_OK},
    '{KIND_SPARE7, 64'd0,   1'b1, 1'b1, 64'd5,   ST_OK},
    '{KIND_PUSH,   64'd100, 1'b0, 1'b0, 64'd0,   ST_OK},
    '{KIND_PUSH,   64'd7,   1'b0, 1'b0, 64'd0,   ST_OK},
    '{KIND_DIV,    64'd0,   1'b0, 1'b0, 64'd0,   ST_OK},
    '{KIND_PUSH,   64'd3,   1'b1, 1'b1, 64'd3,   ST_LEFTOVER}
  };

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic evaluate_token(input logic [2:0] kind, input logic [63:0] val,
                                input logic last, output bit emit, output result_t outcome);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] r;
    emit = 1'b0;
    outcome = '{64'd0, ST_OK};
    if (eval_fault == ST_OK) begin
      case (kind)
        KIND_PUSH: begin
          if (eval_depth >= Depth) begin
            eval_fault = ST_OVERFLOW;
          end else begin
            eval_stack[eval_depth] = val;
            eval_depth++;
          end
        end
        KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
          if (eval_depth < 2) begin
            eval_fault = ST_UNDERFLOW;
          end else begin
            a = eval_stack[eval_depth-1];
            b = eval_stack[eval_depth-2];
            if (kind == KIND_DIV && a == 64'd0) begin
              eval_fault = ST_DIVZERO;
            end else begin
              case (kind)
                KIND_ADD: r = b + a;
                KIND_SUB: r = b - a;
                KIND_MUL: r = b * a;
                default:  r = b / a;
              endcase
              eval_depth--;
              eval_stack[eval_depth-1] = r;
            end
          end
        end
        default: ;
      endcase
    end
    if (last) begin
      emit = 1'b1;
      outcome.top = (eval_depth > 0) ? eval_stack[eval_depth-1] : 64'd0;
      if (eval_fault != ST_OK) outcome.status = eval_fault;
      else if (eval_depth == 0) outcome.status = ST_EMPTY;
      else if (eval_depth > 1) outcome.status = ST_LEFTOVER;
      else outcome.status = ST_OK;
      eval_depth = 0;
      eval_fault = ST_OK;
    end
  endtask

  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] pick_number();
    int unsigned sh;
    sh = $urandom_range(0, 63);
    case ($urandom_range(0, 19))
      0:       return 64'd0;
      1:       return AllOnes;
      2:       return 64'd1;
      3, 4, 5: return 64'($urandom_range(0, 31));
      6:       return 64'd1 << sh;
      7:       return ~(64'd1 << sh);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_token(input token_row_t row);
    int      gap;
    bit      emit;
    result_t outcome;
    gap = idle_span();
    repeat (gap) begin
      @(negedge clk_i);
      tok.valid <= 1'b0;
    end
    @(negedge clk_i);
    tok.valid         <= 1'b1;
    tok.kind          <= row.kind;
    tok.operand_value <= row.val;
    tok.last_token    <= row.last;
    do @(posedge clk_i); while (!tok.ready);
    worked_tokens++;
    evaluate_token(row.kind, row.val, row.last, emit, outcome);
    if (emit) begin
      if (row.typed) outcome = '{row.top, row.status};
      pending_results = {pending_results, outcome};
    end
  endtask

  task automatic send_plain(input logic [2:0] kind, input logic [63:0] val, input logic last);
    send_token('{kind, val, last, 1'b0, 64'd0, ST_OK});
  endtask

  task automatic send_wellformed();
    int nums;
    int pushed;
    int depth;
    nums = ($urandom_range(0, 9) == 0) ? $urandom_range(9, Depth) : $urandom_range(1, 6);
    pushed = 0;
    depth = 0;
    while (pushed < nums || depth > 1) begin
      if ($urandom_range(0, 99) < 8) begin
        send_plain(3'($urandom_range(KIND_SKIP, KIND_SPARE7)), pick_number(), 1'b0);
      end else if (pushed < nums && (depth < 2 || $urandom_range(0, 1))) begin
        pushed++;
        depth++;
        send_plain(KIND_PUSH, pick_number(), pushed == nums && depth == 1);
      end else begin
        depth--;
        send_plain(3'($urandom_range(KIND_ADD, KIND_DIV)), pick_number(),
                   pushed == nums && depth == 1);
      end
    end
  endtask

  task automatic send_overfill();
    int n;
    int ops;
    n = Depth - 1 + $urandom_range(0, 3);
    ops = $urandom_range(0, 2);
    repeat (n) send_plain(KIND_PUSH, pick_number(), 1'b0);
    repeat (ops) send_plain(3'($urandom_range(KIND_ADD, KIND_DIV)), pick_number(), 1'b0);
    send_plain(KIND_SKIP, pick_number(), 1'b1);
  endtask

  task automatic send_noise();
    int len;
    len = $urandom_range(1, 8);
    for (int i = 1; i <= len; i++) begin
      send_plain(3'($urandom_range(0, 7)), pick_number(), i == len);
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= ReportLimit) begin
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected word", 64'd0, res.top_value);
      end else begin
        want = pending_results.pop_front();
        if (res.top_value !== want.top) flag_mismatch("top_value", want.top, res.top_value);
        if (res.status !== want.status) begin
          flag_mismatch("status", 64'(want.status), 64'(res.status));
        end
      end
    end
  end

  initial begin
    int hold;
    hold = 0;
    res.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        res.ready <= 1'b0;
        hold--;
      end else begin
        res.ready <= 1'b1;
        hold = idle_span();
      end
    end
  end

  initial begin
    while (cycles < CycleLimit) @(posedge clk_i) cycles++;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int pick;
    rst_ni            = 1'b0;
    tok.valid         = 1'b0;
    tok.kind          = KIND_SKIP;
    tok.operand_value = 64'd0;
    tok.last_token    = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_token(dir_rows[i]);

    while (worked_tokens < TokenTarget) begin
      calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 65) send_wellformed();
      else if (pick < 75) send_overfill();
      else send_noise();
    end

    @(negedge clk_i);
    tok.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
